// File: rtl/ufe_pkg.sv
// ----------------------------------------------------------------------------
// ufe_pkg
// Shared sizes, command codes and payload types for the disjoint-set engine.
// ----------------------------------------------------------------------------
package ufe_pkg;

  // Table geometry
  localparam int NODES    = 1024;
  localparam int NODE_W   = $clog2(NODES);
  localparam int RANK_W   = 4;
  localparam int COUNT_W  = 11;

  localparam logic [RANK_W-1:0]  RANK_MAX    = {RANK_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(NODES);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(NODES);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Command codes carried by a request
  typedef enum logic [1:0] {
    CMD_FIND  = 2'd0,
    CMD_UNITE = 2'd1,
    CMD_SAME  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

endpackage

// File: rtl/ufe_if.sv
// ----------------------------------------------------------------------------
// ufe_if
// Valid/ready channels of the disjoint-set engine: request, result, config.
// ----------------------------------------------------------------------------
interface ufe_in_if;
  import ufe_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  node_t node_a;
  node_t node_b;

  modport source (output valid, command, node_a, node_b, input ready);
  modport sink   (input valid, command, node_a, node_b, output ready);
endinterface

interface ufe_out_if;
  import ufe_pkg::*;

  logic  valid;
  logic  ready;
  node_t root_a;
  logic  same_set;
  logic  merged;
  logic  bad_node;

  modport source (output valid, root_a, same_set, merged, bad_node, input ready);
  modport sink   (input valid, root_a, same_set, merged, bad_node, output ready);
endinterface

interface ufe_cfg_if;
  import ufe_pkg::*;

  logic   valid;
  logic   ready;
  count_t node_count;

  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

// File: rtl/union_find_engine.sv
// ----------------------------------------------------------------------------
// union_find_engine
// Disjoint-set engine: parent and rank tables in synchronous RAM, union by
// rank, full path compression on every find.
// ----------------------------------------------------------------------------
// Sequence: a rejected or unused request goes straight to the done state; a find
//   walks to the root and then compresses the path, same-set and unite start a
//   second find from B, unite adds the rank fetches of both roots and the link,
//   then the done state. One request in flight; the parent read port, walked one entry a cycle, sets the rate.
// Reset: a clearing pass loads parent[i] = i and rank = 0 into every entry; no
//   request is accepted during it. Config writes are accepted at any time.
// ----------------------------------------------------------------------------
module union_find_engine (
  input  logic      clk,
  input  logic      rst_n,
  ufe_in_if.sink    in_ch,
  ufe_out_if.source out_ch,
  ufe_cfg_if.sink   cfg_ch
);
  import ufe_pkg::*;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_WALK   = 9'b000000100,
    S_COMP   = 9'b000001000,
    S_STARTB = 9'b000010000,
    S_RKA    = 9'b000100000,
    S_RKB    = 9'b001000000,
    S_LINK   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  node_t  clr_idx_r, clr_idx_nxt;
  cmd_t   cmd_r, cmd_nxt;
  node_t  a_r, a_nxt;
  node_t  b_r, b_nxt;
  node_t  cur_r, cur_nxt;
  node_t  root_r, root_nxt;
  node_t  ra_r, ra_nxt;
  rank_t  rka_r, rka_nxt;
  logic   phase_b_r, phase_b_nxt;
  logic   same_r, same_nxt;
  logic   merged_r, merged_nxt;
  logic   bad_r, bad_nxt;
  count_t count_r;

  logic   out_valid_r, out_valid_nxt;
  node_t  out_root_r;
  logic   out_same_r, out_merged_r, out_bad_r;
  logic   out_load;

  // RAM ports
  node_t  parent_mem [NODES];
  rank_t  rank_mem [NODES];
  node_t  p_raddr, p_waddr, p_wdata, p_q;
  logic   p_we;
  node_t  r_raddr, r_waddr;
  rank_t  r_wdata, r_q;
  logic   r_we;

  logic   in_take;
  logic   a_bad, b_bad;
  count_t limit;
  logic   phase_end;
  node_t  end_root;
  node_t  start_node;

  // Parent table: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    p_q <= parent_mem[p_raddr];
  end

  // Rank table
  always_ff @(posedge clk) begin
    if (r_we) begin
      rank_mem[r_waddr] <= r_wdata;
    end
    r_q <= rank_mem[r_raddr];
  end

  // Node count register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_ch.valid) begin
      count_r <= cfg_ch.node_count;
    end
  end

  // Range check against the active node count
  assign limit   = (count_r > COUNT_LIMIT) ? COUNT_LIMIT : count_r;
  assign a_bad   = (COUNT_W'(in_ch.node_a) >= limit);
  assign b_bad   = (COUNT_W'(in_ch.node_b) >= limit);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take = in_ch.valid && in_ch.ready;
  assign start_node = phase_b_r ? b_r : a_r;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    cmd_nxt     = cmd_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    cur_nxt     = cur_r;
    root_nxt    = root_r;
    ra_nxt      = ra_r;
    rka_nxt     = rka_r;
    phase_b_nxt = phase_b_r;
    same_nxt    = same_r;
    merged_nxt  = merged_r;
    bad_nxt     = bad_r;
    out_load    = 1'b0;
    p_raddr     = cur_r;
    p_we        = 1'b0;
    p_waddr     = cur_r;
    p_wdata     = root_r;
    r_raddr     = ra_r;
    r_we        = 1'b0;
    r_waddr     = ra_r;
    r_wdata     = '0;
    phase_end   = 1'b0;
    end_root    = root_r;

    unique case (state_r)
      // Sweep the tables to their initial contents
      S_INIT: begin
        p_we        = 1'b1;
        p_waddr     = clr_idx_r;
        p_wdata     = clr_idx_r;
        r_we        = 1'b1;
        r_waddr     = clr_idx_r;
        r_wdata     = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == node_t'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a request and start the walk from A
      S_IDLE: begin
        p_raddr = in_ch.node_a;
        if (in_take) begin
          cmd_nxt     = in_ch.command;
          a_nxt       = in_ch.node_a;
          b_nxt       = in_ch.node_b;
          ra_nxt      = '0;
          same_nxt    = 1'b0;
          merged_nxt  = 1'b0;
          bad_nxt     = 1'b0;
          phase_b_nxt = 1'b0;
          cur_nxt     = in_ch.node_a;
          if (in_ch.command == CMD_NONE) begin
            state_nxt = S_DONE;
          end else if (a_bad || (in_ch.command != CMD_FIND && b_bad)) begin
            bad_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      // Follow parent pointers until a node points at itself
      S_WALK: begin
        if (p_q == cur_r) begin
          root_nxt = cur_r;
          if (!phase_b_r) begin
            ra_nxt = cur_r;
          end
          if (start_node == cur_r) begin
            phase_end = 1'b1;
            end_root  = cur_r;
          end else begin
            cur_nxt   = start_node;
            p_raddr   = start_node;
            state_nxt = S_COMP;
          end
        end else begin
          cur_nxt = p_q;
          p_raddr = p_q;
        end
      end

      // Point each node on the path at the root
      S_COMP: begin
        p_we    = 1'b1;
        p_waddr = cur_r;
        p_wdata = root_r;
        if (p_q == root_r) begin
          phase_end = 1'b1;
          end_root  = root_r;
        end else begin
          cur_nxt = p_q;
          p_raddr = p_q;
        end
      end

      // Start the walk from B
      S_STARTB: begin
        cur_nxt     = b_r;
        p_raddr     = b_r;
        phase_b_nxt = 1'b1;
        state_nxt   = S_WALK;
      end

      // Fetch the rank of A's root
      S_RKA: begin
        r_raddr   = ra_r;
        state_nxt = S_RKB;
      end

      // Hold A's rank, fetch the rank of B's root
      S_RKB: begin
        rka_nxt   = r_q;
        r_raddr   = root_r;
        state_nxt = S_LINK;
      end

      // Link the lower rank under the higher; on a tie B's root goes under A's and A's rank grows unless saturated
      S_LINK: begin
        merged_nxt = 1'b1;
        p_we       = 1'b1;
        if (rka_r > r_q) begin
          p_waddr = root_r;
          p_wdata = ra_r;
        end else if (rka_r < r_q) begin
          p_waddr = ra_r;
          p_wdata = root_r;
        end else begin
          p_waddr = root_r;
          p_wdata = ra_r;
          r_waddr = ra_r;
          r_wdata = rka_r + 1'b1;
          r_we    = (rka_r != RANK_MAX);
        end
        state_nxt = S_DONE;
      end

      // Hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // Close a find and pick the next step
    if (phase_end) begin
      if (!phase_b_r) begin
        state_nxt = (cmd_r == CMD_FIND) ? S_DONE : S_STARTB;
      end else begin
        same_nxt = (ra_r == end_root);
        if (cmd_r == CMD_UNITE && ra_r != end_root) begin
          state_nxt = S_RKA;
        end else begin
          state_nxt = S_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_idx_r   <= '0;
      phase_b_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      phase_b_r   <= phase_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cur_r    <= cur_nxt;
    root_r   <= root_nxt;
    ra_r     <= ra_nxt;
    rka_r    <= rka_nxt;
    same_r   <= same_nxt;
    merged_r <= merged_nxt;
    bad_r    <= bad_nxt;
  end

  // Output register
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_root_r   <= ra_r;
      out_same_r   <= same_r;
      out_merged_r <= merged_r;
      out_bad_r    <= bad_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.root_a   = out_root_r;
  assign out_ch.same_set = out_same_r;
  assign out_ch.merged   = out_merged_r;
  assign out_ch.bad_node = out_bad_r;

endmodule

// File: test/union_find_checker.sv
// ----------------------------------------------------------------------------
// union_find_checker
// Watches the request, result and config channels of the disjoint-set engine.
// Keeps its own parent and rank tables, predicts each result as requests are
// accepted, and compares every accepted result field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module union_find_checker (
  input  logic clk,
  input  logic rst_n,
  ufe_in_if    in_mon,
  ufe_out_if   out_mon,
  ufe_cfg_if   cfg_mon,
  output int   failures,
  output int   outstanding
);
  import ufe_pkg::*;

  typedef struct packed {
    node_t root_a;
    logic  same_set;
    logic  merged;
    logic  bad_node;
  } outcome_t;

  node_t    parent_tbl [NODES];
  rank_t    rank_tbl [NODES];
  count_t   node_limit;
  outcome_t outcome_q [$];
  int       errs = 0;

  // Walk to the root, then point every node on the path straight at it
  function automatic node_t find_and_flatten(node_t start);
    node_t root;
    node_t cur;
    node_t nxt;
    int    steps;
    root  = start;
    steps = 0;
    while (parent_tbl[root] != root && steps < NODES) begin
      root = parent_tbl[root];
      steps++;
    end
    cur   = start;
    steps = 0;
    while (cur != root && steps < NODES) begin
      nxt = parent_tbl[cur];
      parent_tbl[cur] = root;
      cur = nxt;
      steps++;
    end
    return root;
  endfunction

  // Apply one request to the tables and return the result it should produce
  function automatic outcome_t apply_request(cmd_t cmd, node_t a, node_t b);
    outcome_t res;
    node_t    ra;
    node_t    rb;
    int       lim;
    res = '0;
    lim = (node_limit < COUNT_LIMIT) ? int'(node_limit) : int'(COUNT_LIMIT);
    if (cmd == CMD_NONE) return res;
    if (int'(a) >= lim || (cmd != CMD_FIND && int'(b) >= lim)) begin
      res.bad_node = 1'b1;
      return res;
    end
    ra = find_and_flatten(a);
    res.root_a = ra;
    if (cmd == CMD_FIND) return res;
    rb = find_and_flatten(b);
    res.same_set = (ra == rb);
    // Link by rank; on a tie B's root goes under A's root
    if (cmd == CMD_UNITE && ra != rb) begin
      res.merged = 1'b1;
      if (rank_tbl[ra] > rank_tbl[rb]) begin
        parent_tbl[rb] = ra;
      end else if (rank_tbl[ra] < rank_tbl[rb]) begin
        parent_tbl[ra] = rb;
      end else begin
        parent_tbl[rb] = ra;
        if (rank_tbl[ra] != RANK_MAX) rank_tbl[ra] = rank_tbl[ra] + 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        parent_tbl[i] = node_t'(i);
        rank_tbl[i]   = '0;
      end
      node_limit = COUNT_RESET;
      outcome_q.delete();
    end else begin
      // Compare a delivered result against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t ns: unexpected result, root_a %0d same %0b merged %0b bad %0b",
                   $time, out_mon.root_a, out_mon.same_set, out_mon.merged,
                   out_mon.bad_node);
          errs++;
        end else begin
          want = outcome_q.pop_front();
          check_field("root_a", int'(want.root_a), int'(out_mon.root_a));
          check_field("same_set", int'(want.same_set), int'(out_mon.same_set));
          check_field("merged", int'(want.merged), int'(out_mon.merged));
          check_field("bad_node", int'(want.bad_node), int'(out_mon.bad_node));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) node_limit = cfg_mon.node_count;
      // Predict an accepted request and queue it at the tail
      if (in_mon.valid && in_mon.ready) begin
        outcome_q.insert(outcome_q.size(),
                         apply_request(in_mon.command, in_mon.node_a, in_mon.node_b));
      end
    end
    failures    <= errs;
    outstanding <= outcome_q.size();
  end

endmodule

// File: test/tb_union_find_engine.sv
// ----------------------------------------------------------------------------
// tb_union_find_engine
// Drives find, unite and same-set requests into the disjoint-set engine under
// several node counts: a directed opening over extremes and tie cases, then
// random clustered requests with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_union_find_engine;
  import ufe_pkg::*;

  logic clk;
  logic rst_n;
  bit   calm = 1'b0;
  int   failures;
  int   outstanding;

  ufe_in_if  req_ch ();
  ufe_out_if res_ch ();
  ufe_cfg_if cfg_ch ();

  union_find_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  union_find_checker dsu_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (req_ch),
    .out_mon     (res_ch),
    .cfg_mon     (cfg_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #10_000_000;
    $display("union_find_engine regression: fail");
    $finish;
  end

  // Result side: ready in random runs with occasional stall bursts
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) != 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // Offer one request, with an optional idle burst first; hold until accepted
  task automatic send_request(cmd_t cmd, node_t a, node_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.node_a  <= a;
    req_ch.node_b  <= b;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Hold off until every predicted result has been delivered
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_node_count(count_t n);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.node_count <= n;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly nodes from a small cluster, sometimes anywhere in the index space
  function automatic node_t pick_node(int base, int span);
    if ($urandom_range(0, 99) < 8) return node_t'($urandom_range(0, NODES - 1));
    return node_t'(base + $urandom_range(0, span - 1));
  endfunction

  task automatic random_request(int base, int span);
    int   roll;
    cmd_t cmd;
    roll = $urandom_range(0, 99);
    if (roll < 45)      cmd = CMD_UNITE;
    else if (roll < 75) cmd = CMD_FIND;
    else if (roll < 95) cmd = CMD_SAME;
    else                cmd = CMD_NONE;
    send_request(cmd, pick_node(base, span), pick_node(base, span));
  endtask

  initial begin : stimulus
    int phase_count [8] = '{16, 1024, 64, 2047, 5, 1000, 256, 1024};
    int lim;
    int span;
    int base;

    req_ch.valid      <= 1'b0;
    req_ch.command    <= CMD_FIND;
    req_ch.node_a     <= '0;
    req_ch.node_b     <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.node_count <= COUNT_RESET;
    rst_n             <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, rank ordering, tie linking, compression, unused command
    send_request(CMD_FIND,  10'd0,    10'd0);
    send_request(CMD_FIND,  10'd1023, 10'd1023);
    send_request(CMD_SAME,  10'd0,    10'd1023);
    send_request(CMD_UNITE, 10'd5,    10'd6);
    send_request(CMD_UNITE, 10'd7,    10'd5);
    send_request(CMD_UNITE, 10'd1023, 10'd0);
    send_request(CMD_UNITE, 10'd0,    10'd5);
    send_request(CMD_SAME,  10'd6,    10'd0);
    send_request(CMD_FIND,  10'd6,    10'd1023);
    send_request(CMD_UNITE, 10'd6,    10'd7);
    send_request(CMD_NONE,  10'd1023, 10'd1023);

    // Zero count rejects everything
    wait_drained();
    write_node_count(11'd0);
    send_request(CMD_FIND,  10'd0, 10'd0);
    send_request(CMD_UNITE, 10'd0, 10'd0);
    send_request(CMD_SAME,  10'd0, 10'd0);

    // Single node: only node 0 passes, B checked for unite and same-set
    wait_drained();
    write_node_count(11'd1);
    send_request(CMD_FIND,  10'd0, 10'd1023);
    send_request(CMD_UNITE, 10'd0, 10'd1);
    send_request(CMD_SAME,  10'd0, 10'd0);
    send_request(CMD_UNITE, 10'd0, 10'd0);
    send_request(CMD_FIND,  10'd1, 10'd0);

    // Count beyond the table clamps to the table size
    wait_drained();
    write_node_count(11'd2047);
    send_request(CMD_FIND,  10'd1023, 10'd0);
    send_request(CMD_SAME,  10'd1023, 10'd1000);

    // Top index just out of range
    wait_drained();
    write_node_count(11'd1023);
    send_request(CMD_FIND,  10'd1023, 10'd0);
    send_request(CMD_UNITE, 10'd1022, 10'd1023);
    send_request(CMD_FIND,  10'd1022, 10'd0);

    // Random phases, one node count each; the last phase runs without stalls
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_node_count(count_t'(phase_count[p]));
      calm = (p == 7);
      lim  = (phase_count[p] < NODES) ? phase_count[p] : NODES;
      span = (lim < 40) ? lim : 40;
      for (int k = 0; k < 100; k++) begin
        if (k % 25 == 0) base = $urandom_range(0, lim - span);
        if (p == 2 && k == 50) wait_drained();
        random_request(base, span);
      end
    end

    // Drain and settle
    wait_drained();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("union_find_engine regression: pass");
    end else begin
      $display("union_find_engine regression: fail");
    end
    $finish;
  end

endmodule
